/* design/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int WordWidth  = 32;
  localparam int BlockWords = 16;
  localparam int ExpDepth   = 68;
  localparam int Rounds     = 64;

  localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
  localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  SM3_PAD    = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,     // wait for an input beat
    ST_PAD,      // write padding words
    ST_EXPAND,   // expand W16..W67 through the memory
    ST_ROUND,    // run 64 rounds
    ST_FOLD,     // xor working registers into chaining value
    ST_OUT,      // emit digest words
    ST_RESTORE   // return chaining value to IV
  } state_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h7380166F;
      3'd1: v = 32'h4914B2B9;
      3'd2: v = 32'h172442D7;
      3'd3: v = 32'hDA8A0600;
      3'd4: v = 32'hA96F30BC;
      3'd5: v = 32'h163138AA;
      3'd6: v = 32'hE38DEE4D;
      default: v = 32'hB0FB0E4E;
    endcase
    return v;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

/* design/sm3_ram.sv */
// ----------------------------------------------------------------------------
// sm3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sm3_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/sm3_round.sv */
// ----------------------------------------------------------------------------
// sm3_round
// One SM3 compression round over the working registers A..H.
// ----------------------------------------------------------------------------
module sm3_round (
  input  logic [5:0]            round,
  input  sm3_pkg::word_t [7:0]  regs,
  input  sm3_pkg::word_t        wj,
  input  sm3_pkg::word_t        wj4,
  output sm3_pkg::word_t [7:0]  regs_next
);
  import sm3_pkg::*;

  word_t a12, ss1, ss2, fv, gv, tt1, tt2, tj;
  logic  early;

  // evaluate one round
  always_comb begin
    early = (round < 6'd16);
    tj    = early ? SM3_T_LOW : SM3_T_HIGH;
    a12   = rotl(regs[0], 5'd12);
    ss1   = rotl(a12 + regs[4] + rotl(tj, round[4:0]), 5'd7);
    ss2   = ss1 ^ a12;
    if (early) begin
      fv = regs[0] ^ regs[1] ^ regs[2];
      gv = regs[4] ^ regs[5] ^ regs[6];
    end else begin
      fv = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
      gv = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
    end
    tt1 = fv + regs[3] + ss2 + (wj ^ wj4);
    tt2 = gv + regs[7] + ss1 + wj;
    regs_next[0] = tt1;
    regs_next[1] = regs[0];
    regs_next[2] = rotl(regs[1], 5'd9);
    regs_next[3] = regs[2];
    regs_next[4] = perm0(tt2);
    regs_next[5] = regs[4];
    regs_next[6] = rotl(regs[5], 5'd19);
    regs_next[7] = regs[6];
  end

endmodule

/* design/sm3_hash_engine.sv */
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 256-bit hash over a byte stream, memory-based message schedule.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready/in_data) carries one message
// byte per beat, with byte_valid and end_of_message flags. A beat with
// end_of_message closes the message. The engine pads the message and then
// emits eight digest beats on the output channel (out_valid/out_ready/out_data).
// Word 0 comes first, and last_word is set on word 7.
// Bytes are packed into 32-bit words and written to the schedule memory, and
// bytes can follow back to back inside a block.
// A full block then runs one compression, with in_ready low throughout:
// - 52 expansion words, each gathering five taps through one read port,
// - 64 rounds, with two reads per round,
// - a fold of the working registers into the chaining value.
// The closing beat adds a padding pass over the 16 block words plus one
// compression. A second padding block, with its own compression, is needed
// when 56 or more bytes remain in the block.
// The memory read port is the limiting resource.
// Reset returns the chaining value to the IV and empties the byte buffer.
// A stalled output holds the current digest word; no input is taken until
// all eight words are delivered and the restore state returns the IV.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sm3_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sm3_pkg::out_beat_t  out_data
);
  import sm3_pkg::*;

  localparam int         AW        = $clog2(ExpDepth);
  localparam logic [6:0] ExpLast   = 7'(ExpDepth - BlockWords - 1);
  localparam logic [6:0] RoundLast = 7'(Rounds - 1);

  // control
  state_t       state, state_next;
  logic [5:0]   fill;          // bytes held in current block
  logic [60:0]  byte_count;
  logic         ending;        // message end seen, digest pending
  logic         padded;        // 0x80 byte already written
  logic         len_written;   // length words already written
  logic [6:0]   step;          // counter for pad/expand/round phases
  logic [2:0]   sub;           // sub-step inside expand/round
  logic [2:0]   widx;
  logic [23:0]  acc;           // partial word of the buffer
  logic         in_fire;

  word_t        cv [8];
  word_t [7:0]  regs, regs_next;
  word_t        tap [4];       // expansion taps: w[i-16], w[i-9], w[i-3], w[i-13]
  word_t        wj;

  // memory
  logic          m_we;
  logic [AW-1:0] m_wa, m_ra;
  word_t         m_wd, m_rd;

  // padding
  logic [63:0]   bits;
  logic          len_fits;
  logic [3:0]    pad_start;
  word_t         pad_first;
  word_t         pad_word;

  // expansion
  word_t         wnew;
  logic [AW-1:0] exp_i;

  sm3_ram #(.Width(WordWidth), .Depth(ExpDepth)) u_wmem (
    .clk(clk), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
    .rd_addr(m_ra), .rd_data(m_rd)
  );

  sm3_round u_round (
    .round(step[5:0]), .regs(regs), .wj(wj), .wj4(m_rd), .regs_next(regs_next)
  );

  assign in_fire = in_valid && in_ready;

  // first padding word: leftover bytes, then 0x80
  always_comb begin
    case (fill[1:0])
      2'd0: pad_first = {SM3_PAD, 24'h0};
      2'd1: pad_first = {acc[7:0], SM3_PAD, 16'h0};
      2'd2: pad_first = {acc[15:0], SM3_PAD, 8'h0};
      default: pad_first = {acc, SM3_PAD};
    endcase
  end

  // padding word at the current word slot
  always_comb begin
    bits      = {byte_count, 3'b000};
    len_fits  = padded || (fill < 6'd56);
    pad_start = padded ? 4'd0 : fill[5:2];
    pad_word  = '0;
    if (!padded && step[3:0] == fill[5:2]) begin
      pad_word = pad_first;
    end else if (len_fits && step[3:0] == 4'd14) begin
      pad_word = bits[63:32];
    end else if (len_fits && step[3:0] == 4'd15) begin
      pad_word = bits[31:0];
    end
  end

  // expansion result; the last tap w[i-6] comes straight from the memory
  always_comb begin
    wnew = perm1(tap[0] ^ tap[1] ^ rotl(tap[2], 5'd15)) ^ rotl(tap[3], 5'd7) ^ m_rd;
  end

  // index of the word being built
  always_comb begin
    exp_i = AW'(step) + AW'(16);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.byte_valid && fill == 6'd63) begin
            state_next = ST_EXPAND;
          end else if (in_data.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD:    if (step[3:0] == 4'd15) state_next = ST_EXPAND;
      ST_EXPAND: if (step == ExpLast && sub == 3'd5) state_next = ST_ROUND;
      ST_ROUND:  if (step == RoundLast && sub == 3'd2) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!ending)          state_next = ST_IDLE;
        else if (len_written) state_next = ST_OUT;
        else                  state_next = ST_PAD;
      end
      ST_OUT:     if (out_ready && widx == 3'd7) state_next = ST_RESTORE;
      ST_RESTORE: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data.digest_word = cv[widx];
    out_data.word_index  = widx;
    out_data.last_word   = (widx == 3'd7);
    m_we = 1'b0;
    m_wa = '0;
    m_wd = '0;
    m_ra = '0;
    case (state)
      ST_IDLE: begin
        m_we = in_fire && in_data.byte_valid && fill[1:0] == 2'd3;
        m_wa = AW'(fill[5:2]);
        m_wd = {acc, in_data.msg_byte};
      end
      ST_PAD: begin
        m_we = (step[3:0] >= pad_start);
        m_wa = AW'(step[3:0]);
        m_wd = pad_word;
      end
      ST_EXPAND: begin
        case (sub)
          3'd0: m_ra = exp_i - AW'(16);
          3'd1: m_ra = exp_i - AW'(9);
          3'd2: m_ra = exp_i - AW'(3);
          3'd3: m_ra = exp_i - AW'(13);
          3'd4: m_ra = exp_i - AW'(6);
          default: m_ra = '0;
        endcase
        m_we = (sub == 3'd5);
        m_wa = exp_i;
        m_wd = wnew;
      end
      ST_ROUND: begin
        m_ra = (sub == 3'd0) ? AW'(step) : AW'(step + 7'd4);
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      byte_count  <= '0;
      ending      <= 1'b0;
      padded      <= 1'b0;
      len_written <= 1'b0;
      step        <= '0;
      sub         <= '0;
      widx        <= '0;
      acc         <= '0;
      for (int k = 0; k < 8; k++) cv[k] <= iv_word(3'(k));
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          step <= '0;
          sub  <= '0;
          if (in_fire) begin
            if (in_data.byte_valid) begin
              acc        <= {acc[15:0], in_data.msg_byte};
              fill       <= fill + 6'd1;
              byte_count <= byte_count + 61'd1;
            end
            if (in_data.end_of_message) begin
              ending <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          step <= step + 7'd1;
          if (step[3:0] == 4'd15) begin
            step   <= '0;
            padded <= 1'b1;
            fill   <= '0;
            if (len_fits) len_written <= 1'b1;
          end
        end
        ST_EXPAND: begin
          // gather taps, then write the new word
          if (sub inside {[3'd1:3'd4]}) tap[2'(sub - 3'd1)] <= m_rd;
          if (sub == 3'd5) begin
            sub <= '0;
            if (step == ExpLast) begin
              step <= '0;
              for (int k = 0; k < 8; k++) regs[k] <= cv[k];
            end else begin
              step <= step + 7'd1;
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        ST_ROUND: begin
          if (sub == 3'd0) begin
            sub <= 3'd1;
          end else if (sub == 3'd1) begin
            wj  <= m_rd;
            sub <= 3'd2;
          end else begin
            regs <= regs_next;
            sub  <= '0;
            step <= step + 7'd1;
          end
        end
        ST_FOLD: begin
          for (int k = 0; k < 8; k++) cv[k] <= cv[k] ^ regs[k];
          step <= '0;
          sub  <= '0;
        end
        ST_OUT: begin
          if (out_ready) widx <= widx + 3'd1;
        end
        ST_RESTORE: begin
          for (int k = 0; k < 8; k++) cv[k] <= iv_word(3'(k));
          fill        <= '0;
          byte_count  <= '0;
          ending      <= 1'b0;
          padded      <= 1'b0;
          len_written <= 1'b0;
          widx        <= '0;
          acc         <= '0;
        end
        default: ;
      endcase
    end
  end

  // digest beats are only shown after a message ends
  property p_out_after_end;
    @(posedge clk) disable iff (rst) out_valid |-> ending;
  endproperty
  assert property (p_out_after_end) else $error("digest without message end");

  property p_no_in_while_out;
    @(posedge clk) disable iff (rst) out_valid |-> !in_ready;
  endproperty
  assert property (p_no_in_while_out) else $error("input taken during digest");

  property p_hold_word;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> $stable(widx);
  endproperty
  assert property (p_hold_word) else $error("digest index moved under stall");

  property p_hold_beat;
    @(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
  endproperty
  assert property (p_hold_beat) else $error("digest beat changed under stall");

endmodule
